/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the directory RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent true in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// condition must never hold
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

/* rtl/core/hkd_pkg.sv */
// ----------------------------------------------------------------------------
// hkd_pkg
// Types and constants of the hashed key directory.
// ----------------------------------------------------------------------------
package hkd_pkg;

   // request operations; code 3 behaves as lookup
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;
   localparam logic [1:0] FUNC_SPARE  = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_MATCH = 2'd0;
   localparam logic [1:0] STATUS_FREE  = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   // case folding
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // one-at-a-time hash
   localparam int HASH_W        = 32;
   localparam int HASH_MIX_SHL  = 10;
   localparam int HASH_MIX_SHR  = 6;
   localparam int HASH_FIN_SHL0 = 3;
   localparam int HASH_FIN_SHR  = 11;
   localparam int HASH_FIN_SHL1 = 15;

   // remainder steps: product, quotient, subtract
   localparam int MOD_CYCLES = 3;
   localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      FRONT_IDLE,
      FRONT_HASH,
      FRONT_FINAL,
      FRONT_MOD,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_CHECK
   } back_state_type;

   // classification of a queued request
   typedef struct packed {
      logic [1:0] func;
      logic       empty;
   } entry_ctrl_type;

   localparam int CTRL_W = $bits(entry_ctrl_type);

   typedef struct packed {
      logic clearing;
      logic probing;
   } back_status_type;

endpackage

/* rtl/core/hashed_key_directory_linear_probe.sv */
// ----------------------------------------------------------------------------
// hashed_key_directory_linear_probe
// Open-addressed key directory with linear probing on a hashed start slot.
//
//   channel  signals                        direction
//   req      req_valid/ready, func, key     in
//   rsp      rsp_valid/ready, slot, status  out
//
// Front: accept, one hash step per key character, finalize, three remainder
// steps (none for a power-of-two TABLE_SLOTS), then hand off to the queue.
// Back: one probed slot per cycle plus a dequeue step, set by the single read
// port of the slot memory. Front and back overlap through a 2-entry queue.
// After reset a clearing pass frees all slots; req_ready stays low until it
// ends. A stalled rsp holds the back; the front still accepts until the queue
// fills.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hashed_key_directory_linear_probe #(
   parameter int TABLE_SLOTS = 1024,
   parameter int KEY_CHARS   = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_func,
   input  logic [8*KEY_CHARS-1:0]         req_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [$clog2(TABLE_SLOTS)-1:0] rsp_slot,
   output logic [1:0]                     rsp_status
);

   localparam int SLOT_W  = $clog2(TABLE_SLOTS);
   localparam int KEY_W   = 8 * KEY_CHARS;
   localparam int ENTRY_W = hkd_pkg::CTRL_W + KEY_W + SLOT_W;

   hkd_pkg::back_status_type back_status;
   hkd_pkg::entry_ctrl_type  push_ctrl, pop_ctrl;
   logic                     push_valid, push_ready;
   logic [KEY_W-1:0]         push_key, pop_key;
   logic [SLOT_W-1:0]        push_start, pop_start;
   logic                     pop_valid, pop_ready;
   logic [ENTRY_W-1:0]       push_data, pop_data;

   hkd_front #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .KEY_CHARS   (KEY_CHARS),
      .SLOT_W      (SLOT_W),
      .KEY_W       (KEY_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_key     (req_key),
      .back_status (back_status),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_ctrl   (push_ctrl),
      .push_key    (push_key),
      .push_start  (push_start)
   );

   assign push_data = {push_ctrl, push_key, push_start};

   hkd_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_ctrl  = hkd_pkg::entry_ctrl_type'(pop_data[ENTRY_W-1 -: hkd_pkg::CTRL_W]);
   assign pop_key   = pop_data[SLOT_W +: KEY_W];
   assign pop_start = pop_data[SLOT_W-1:0];

   hkd_back #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .KEY_CHARS   (KEY_CHARS),
      .SLOT_W      (SLOT_W),
      .KEY_W       (KEY_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_ctrl    (pop_ctrl),
      .pop_key     (pop_key),
      .pop_start   (pop_start),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_slot    (rsp_slot),
      .rsp_status  (rsp_status),
      .back_status (back_status)
   );

   // no transfer on req while slots are being cleared
   `ASSERT_NEVER(a_no_req_in_clear, clock, reset, req_ready && back_status.clearing)
   // nothing reaches the queue during the clearing pass
   `ASSERT_IMPLIES(a_queue_empty_in_clear, clock, reset, back_status.clearing, !pop_valid)
   // the result register is empty for the whole probe walk
   `ASSERT_IMPLIES(a_rsp_free_in_probe, clock, reset, back_status.probing, !rsp_valid)
   // rejected empty key always reports slot zero
   `ASSERT_IMPLIES(a_empty_slot_zero, clock, reset, rsp_valid && (rsp_status == hkd_pkg::STATUS_EMPTY), rsp_slot == '0)

endmodule

/* rtl/core/hkd_front.sv */
// ----------------------------------------------------------------------------
// hkd_front
// Accepts requests, folds the key, hashes it and reduces it to a start slot.
// ----------------------------------------------------------------------------
module hkd_front #(
   parameter int TABLE_SLOTS = 1024,
   parameter int KEY_CHARS   = 5,
   parameter int SLOT_W      = $clog2(TABLE_SLOTS),
   parameter int KEY_W       = 8 * KEY_CHARS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   input  logic [KEY_W-1:0]       req_key,
   input  hkd_pkg::back_status_type back_status,
   output logic                   push_valid,
   input  logic                   push_ready,
   output hkd_pkg::entry_ctrl_type push_ctrl,
   output logic [KEY_W-1:0]       push_key,
   output logic [SLOT_W-1:0]      push_start
);

   localparam int  CHAR_IDX_W = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
   localparam bit  IS_POW2    = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
   localparam int  MUL_W      = 2 * hkd_pkg::HASH_W;
   localparam int  PROD_W     = MUL_W + 1;
   // ceil(2^(HASH_W+SLOT_W) / TABLE_SLOTS): exact quotient for any 32-bit hash
   localparam logic [63:0] RECIP =
      ((64'd1 << (hkd_pkg::HASH_W + SLOT_W)) + 64'(TABLE_SLOTS) - 64'd1) /
      64'(TABLE_SLOTS);
   localparam logic [hkd_pkg::HASH_W-1:0] RECIP_LO = RECIP[hkd_pkg::HASH_W-1:0];
   localparam logic                       RECIP_HI = RECIP[hkd_pkg::HASH_W];
   localparam logic [SLOT_W-1:0]          DIV_LO   = SLOT_W'(TABLE_SLOTS);

   hkd_pkg::front_state_type state_ff, state_in;
   logic [KEY_W-1:0]                 key_ff, key_in;
   logic [1:0]                       func_ff, func_in;
   logic [hkd_pkg::HASH_W-1:0]       hash_ff, hash_in;
   logic [PROD_W-1:0]                prod_ff, prod_in;
   logic [hkd_pkg::HASH_W-1:0]       quot_ff, quot_in;
   logic [SLOT_W-1:0]                start_ff, start_in;
   logic [CHAR_IDX_W-1:0]            char_idx_ff, char_idx_in;
   logic [hkd_pkg::MOD_CNT_W-1:0]    mod_cnt_ff, mod_cnt_in;
   logic [KEY_W-1:0]                 key_fold;

   // lower-case fold, each byte on its own
   always_comb begin
      for (int i = 0; i < KEY_CHARS; i++) begin
         if (req_key[8*i +: 8] >= hkd_pkg::CHAR_UPPER_A &&
             req_key[8*i +: 8] <= hkd_pkg::CHAR_UPPER_Z) begin
            key_fold[8*i +: 8] = req_key[8*i +: 8] + hkd_pkg::CASE_OFFSET;
         end else begin
            key_fold[8*i +: 8] = req_key[8*i +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hkd_pkg::FRONT_IDLE;
         char_idx_ff <= '0;
         mod_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         char_idx_ff <= char_idx_in;
         mod_cnt_ff  <= mod_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      func_ff  <= func_in;
      hash_ff  <= hash_in;
      prod_ff  <= prod_in;
      quot_ff  <= quot_in;
      start_ff <= start_in;
   end

   always_comb begin
      logic [hkd_pkg::HASH_W-1:0] h;
      logic [MUL_W-1:0]           p;
      logic [PROD_W-1:0]          sum;
      state_in    = state_ff;
      key_in      = key_ff;
      func_in     = func_ff;
      hash_in     = hash_ff;
      prod_in     = prod_ff;
      quot_in     = quot_ff;
      start_in    = start_ff;
      char_idx_in = char_idx_ff;
      mod_cnt_in  = mod_cnt_ff;
      req_ready   = 1'b0;
      push_valid  = 1'b0;
      h           = hash_ff;
      p           = '0;
      sum         = '0;
      unique case (state_ff)
         hkd_pkg::FRONT_IDLE: begin
            req_ready = !back_status.clearing;
            if (req_valid && !back_status.clearing) begin
               key_in      = key_fold;
               func_in     = req_func;
               hash_in     = '0;
               char_idx_in = CHAR_IDX_W'(KEY_CHARS - 1);
               state_in    = hkd_pkg::FRONT_HASH;
            end
         end
         hkd_pkg::FRONT_HASH: begin
            // one character per cycle, first character in the top byte
            h = hash_ff + hkd_pkg::HASH_W'(key_ff[8*char_idx_ff +: 8]);
            h = h + (h << hkd_pkg::HASH_MIX_SHL);
            h = h ^ (h >> hkd_pkg::HASH_MIX_SHR);
            hash_in = h;
            if (char_idx_ff == '0) begin
               state_in = hkd_pkg::FRONT_FINAL;
            end else begin
               char_idx_in = char_idx_ff - 1'b1;
            end
         end
         hkd_pkg::FRONT_FINAL: begin
            h = hash_ff + (hash_ff << hkd_pkg::HASH_FIN_SHL0);
            h = h ^ (h >> hkd_pkg::HASH_FIN_SHR);
            h = h + (h << hkd_pkg::HASH_FIN_SHL1);
            hash_in = h;
            if (IS_POW2) begin
               start_in = h[SLOT_W-1:0];
               state_in = hkd_pkg::FRONT_PUSH;
            end else begin
               mod_cnt_in = '0;
               state_in   = hkd_pkg::FRONT_MOD;
            end
         end
         hkd_pkg::FRONT_MOD: begin
            // reciprocal multiply: product, quotient, then hash - quotient * slots
            priority if (mod_cnt_ff == '0) begin
               p          = MUL_W'(hash_ff) * MUL_W'(RECIP_LO);
               prod_in    = {1'b0, p};
               mod_cnt_in = mod_cnt_ff + 1'b1;
            end else if (mod_cnt_ff == hkd_pkg::MOD_CNT_W'(1)) begin
               sum = prod_ff +
                     (RECIP_HI ? {1'b0, hash_ff, {hkd_pkg::HASH_W{1'b0}}} : '0);
               quot_in    = hkd_pkg::HASH_W'(sum >> (hkd_pkg::HASH_W + SLOT_W));
               mod_cnt_in = mod_cnt_ff + 1'b1;
            end else begin
               // remainder is below the slot count, so the low bits suffice
               start_in = hash_ff[SLOT_W-1:0] - SLOT_W'(quot_ff[SLOT_W-1:0] * DIV_LO);
               state_in = hkd_pkg::FRONT_PUSH;
            end
         end
         hkd_pkg::FRONT_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = hkd_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = hkd_pkg::FRONT_IDLE;
         end
      endcase
   end

   assign push_ctrl.func  = func_ff;
   assign push_ctrl.empty = (key_ff[KEY_W-1 -: 8] == 8'h00);
   assign push_key        = key_ff;
   assign push_start      = start_ff;

endmodule

/* rtl/core/hkd_queue.sv */
// ----------------------------------------------------------------------------
// hkd_queue
// Short FIFO between the classifying front and the probing back.
// ----------------------------------------------------------------------------
module hkd_queue #(
   parameter int DATA_W = 53
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0]               entry_ff [hkd_pkg::QUEUE_DEPTH];
   logic [hkd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hkd_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hkd_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                            do_push, do_pop;

   localparam logic [hkd_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      hkd_pkg::QUEUE_PTR_W'(hkd_pkg::QUEUE_DEPTH - 1);

   assign push_ready = (count_ff != hkd_pkg::QUEUE_CNT_W'(hkd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/hkd_back.sv */
// ----------------------------------------------------------------------------
// hkd_back
// Probe engine: owns the slot memories, walks slots, updates and reports.
// ----------------------------------------------------------------------------
module hkd_back #(
   parameter int TABLE_SLOTS = 1024,
   parameter int KEY_CHARS   = 5,
   parameter int SLOT_W      = $clog2(TABLE_SLOTS),
   parameter int KEY_W       = 8 * KEY_CHARS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  hkd_pkg::entry_ctrl_type pop_ctrl,
   input  logic [KEY_W-1:0]        pop_key,
   input  logic [SLOT_W-1:0]       pop_start,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SLOT_W-1:0]       rsp_slot,
   output logic [1:0]              rsp_status,
   output hkd_pkg::back_status_type back_status
);

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

   hkd_pkg::back_state_type state_ff, state_in;

   logic                used_mem_ff [TABLE_SLOTS];
   logic [KEY_W-1:0]    key_mem_ff  [TABLE_SLOTS];
   logic                used_rd_ff;
   logic [KEY_W-1:0]    key_rd_ff;

   logic [KEY_W-1:0]    key_ff, key_in;
   logic [1:0]          func_ff, func_in;
   logic [SLOT_W-1:0]   start_ff, start_in;
   logic [SLOT_W-1:0]   probe_ff, probe_in;
   logic [SLOT_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]   clr_addr_ff, clr_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic                rd_en;
   logic [SLOT_W-1:0]   rd_addr;
   logic                used_we, used_wdata, key_we;
   logic [SLOT_W-1:0]   wr_addr;
   logic                out_free;
   logic [SLOT_W-1:0]   probe_next;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign probe_next = (probe_ff == SLOT_LAST) ? '0 : probe_ff + 1'b1;

   // slot memories: one write port, registered read
   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem_ff[wr_addr] <= used_wdata;
      end
      if (key_we) begin
         key_mem_ff[wr_addr] <= key_ff;
      end
      if (rd_en) begin
         used_rd_ff <= used_mem_ff[rd_addr];
         key_rd_ff  <= key_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hkd_pkg::BACK_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      func_ff       <= func_in;
      start_ff      <= start_in;
      probe_ff      <= probe_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      logic load;
      state_in      = state_ff;
      key_in        = key_ff;
      func_in       = func_ff;
      start_in      = start_ff;
      probe_in      = probe_ff;
      count_in      = count_ff;
      clr_addr_in   = clr_addr_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      pop_ready     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = probe_next;
      used_we       = 1'b0;
      used_wdata    = 1'b0;
      key_we        = 1'b0;
      wr_addr       = probe_ff;
      load          = 1'b0;
      unique case (state_ff)
         hkd_pkg::BACK_CLEAR: begin
            used_we = 1'b1;
            wr_addr = clr_addr_ff;
            if (clr_addr_ff == SLOT_LAST) begin
               state_in = hkd_pkg::BACK_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         hkd_pkg::BACK_IDLE: begin
            // take work only when the result register will be free
            if (pop_valid && out_free) begin
               pop_ready = 1'b1;
               if (pop_ctrl.empty) begin
                  load          = 1'b1;
                  rsp_slot_in   = '0;
                  rsp_status_in = hkd_pkg::STATUS_EMPTY;
               end else begin
                  key_in   = pop_key;
                  func_in  = pop_ctrl.func;
                  start_in = pop_start;
                  probe_in = pop_start;
                  count_in = '0;
                  rd_en    = 1'b1;
                  rd_addr  = pop_start;
                  state_in = hkd_pkg::BACK_CHECK;
               end
            end
         end
         hkd_pkg::BACK_CHECK: begin
            priority if (!used_rd_ff) begin
               load          = 1'b1;
               rsp_slot_in   = probe_ff;
               rsp_status_in = hkd_pkg::STATUS_FREE;
               if (func_ff == hkd_pkg::FUNC_INSERT) begin
                  used_we    = 1'b1;
                  used_wdata = 1'b1;
                  key_we     = 1'b1;
               end
               state_in = hkd_pkg::BACK_IDLE;
            end else if (key_rd_ff == key_ff) begin
               load          = 1'b1;
               rsp_slot_in   = probe_ff;
               rsp_status_in = hkd_pkg::STATUS_MATCH;
               if (func_ff == hkd_pkg::FUNC_REMOVE) begin
                  used_we = 1'b1;
               end
               state_in = hkd_pkg::BACK_IDLE;
            end else if (count_ff == SLOT_LAST) begin
               // every slot probed without a hit
               load          = 1'b1;
               rsp_slot_in   = start_ff;
               rsp_status_in = hkd_pkg::STATUS_FULL;
               state_in      = hkd_pkg::BACK_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = probe_next;
               probe_in = probe_next;
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            state_in = hkd_pkg::BACK_IDLE;
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_status           = rsp_status_ff;
   assign back_status.clearing = (state_ff == hkd_pkg::BACK_CLEAR);
   assign back_status.probing  = (state_ff == hkd_pkg::BACK_CHECK);

endmodule

/* verif/hashed_key_directory_linear_probe_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_key_directory_linear_probe_tb
// Drives insert/remove/lookup requests into the directory and checks every
// reply's slot and status against a cycle-free model of the probe table.
// Covers case folding, empty keys, collision chains, wrap at the top slot
// and holes left by removes.
// ----------------------------------------------------------------------------
module hashed_key_directory_linear_probe_tb;

   localparam int SLOTS       = 1024;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int IDLE_PCT    = 24;

   typedef struct {
      logic [1:0]  func;
      logic [39:0] key;
   } dir_req_type;

   typedef struct packed {
      logic [9:0] slot;
      logic [1:0] status;
   } dir_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = hkd_pkg::FUNC_LOOKUP;
   logic [39:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [9:0]  rsp_slot;
   logic [1:0]  rsp_status;

   dir_req_type    request_q[$];
   dir_result_type slot_status_q[$];
   int             errors = 0;
   int             cycle_cnt = 0;

   // model of the probe table
   bit          table_used[SLOTS];
   logic [39:0] table_key[SLOTS];

   hashed_key_directory_linear_probe DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_slot   (rsp_slot),
      .rsp_status (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [39:0] fold_key(logic [39:0] k);
      logic [39:0] r;
      logic [7:0]  c;
      r = '0;
      for (int i = 0; i < 5; i++) begin
         c = k[8*i +: 8];
         if (c >= 8'h41 && c <= 8'h5A)
            c = c + 8'h20;
         r[8*i +: 8] = c;
      end
      return r;
   endfunction

   // one-at-a-time hash of the folded key, reduced to a slot
   function automatic logic [9:0] start_slot(logic [39:0] raw);
      logic [39:0] k;
      logic [31:0] h;
      k = fold_key(raw);
      h = '0;
      for (int i = 4; i >= 0; i--) begin
         h = h + {24'd0, k[8*i +: 8]};
         h = h + (h << 10);
         h = h ^ (h >> 6);
      end
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      return h[9:0];
   endfunction

   function automatic dir_result_type probe_table(logic [1:0] func, logic [39:0] raw);
      logic [39:0]    k;
      logic [9:0]     first;
      logic [9:0]     s;
      logic [1:0]     st;
      int             n;
      dir_result_type r;
      k = fold_key(raw);
      if (k[39:32] == 8'h00) begin
         r.slot   = '0;
         r.status = hkd_pkg::STATUS_EMPTY;
         return r;
      end
      first = start_slot(k);
      s     = first;
      st    = hkd_pkg::STATUS_FULL;
      n     = 0;
      while (n < SLOTS && st == hkd_pkg::STATUS_FULL) begin
         if (!table_used[s])
            st = hkd_pkg::STATUS_FREE;
         else if (table_key[s] == k)
            st = hkd_pkg::STATUS_MATCH;
         else begin
            s = s + 10'd1;
            n++;
         end
      end
      if (st == hkd_pkg::STATUS_FULL)
         s = first;
      if (func == hkd_pkg::FUNC_INSERT && st == hkd_pkg::STATUS_FREE) begin
         table_used[s] = 1'b1;
         table_key[s]  = k;
      end else if (func == hkd_pkg::FUNC_REMOVE && st == hkd_pkg::STATUS_MATCH) begin
         table_used[s] = 1'b0;
      end
      r.slot   = s;
      r.status = st;
      return r;
   endfunction

   function automatic logic [39:0] rand_word();
      logic [39:0] k;
      for (int i = 0; i < 5; i++)
         k[8*i +: 8] = 8'h61 + 8'($urandom_range(25));
      return k;
   endfunction

   function automatic logic [39:0] rand_any_key();
      logic [39:0] k;
      k[39:32] = 8'($urandom_range(255));
      k[31:0]  = $urandom;
      return k;
   endfunction

   // random upper/lower case spelling of the same key
   function automatic logic [39:0] mix_case(logic [39:0] k);
      logic [39:0] r;
      r = k;
      for (int i = 0; i < 5; i++)
         if (r[8*i +: 8] >= 8'h61 && r[8*i +: 8] <= 8'h7A && $urandom_range(1) == 1)
            r[8*i +: 8] = r[8*i +: 8] - 8'h20;
      return r;
   endfunction

   function automatic logic [39:0] find_key_at(logic [9:0] slot);
      logic [39:0] k;
      k = rand_word();
      while (start_slot(k) != slot)
         k = rand_word();
      return k;
   endfunction

   function automatic logic [1:0] rand_func();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) return hkd_pkg::FUNC_INSERT;
      if (roll < 65) return hkd_pkg::FUNC_REMOVE;
      if (roll < 95) return hkd_pkg::FUNC_LOOKUP;
      return hkd_pkg::FUNC_SPARE;
   endfunction

   function automatic bit no_idle_window();
      return (cycle_cnt % 25000) < 5000;
   endfunction

   task automatic push_req(logic [1:0] func, logic [39:0] key);
      dir_req_type item;
      item.func = func;
      item.key  = key;
      request_q = {request_q, item};
   endtask

   // sampled away from the rising edge so driver updates have settled
   task automatic wait_drained();
      do
         @(negedge clock);
      while (request_q.size() != 0 || req_valid || slot_status_q.size() != 0);
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      dir_req_type    item;
      dir_result_type pred;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            pred          = probe_table(req_func, req_key);
            slot_status_q = {slot_status_q, pred};
         end
         if (!req_valid || req_ready) begin
            if (request_q.size() != 0 &&
                (no_idle_window() || $urandom_range(99) >= IDLE_PCT)) begin
               item = request_q.pop_front();
               req_valid <= 1'b1;
               req_func  <= item.func;
               req_key   <= item.key;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      dir_result_type want;
      cycle_cnt <= cycle_cnt + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle_window() || $urandom_range(99) >= IDLE_PCT;
         if (rsp_valid && rsp_ready) begin
            if (slot_status_q.size() == 0) begin
               $error("unexpected transfer: slot %0d status %0d", rsp_slot, rsp_status);
               errors++;
            end else begin
               want = slot_status_q.pop_front();
               if (rsp_slot !== want.slot) begin
                  $error("slot mismatch: expected %0d, got %0d", want.slot, rsp_slot);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, rsp_status);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      logic [39:0] pair_a, pair_b, top_a, top_b, k;
      logic [39:0] key_pool[$];
      bit          near;
      int          roll;

      // pool of keys whose start slots cluster, so probes run into each other
      for (int i = 0; i < 8; i++)
         key_pool = {key_pool, rand_word()};
      while (key_pool.size() < 48) begin
         k = ($urandom_range(7) == 0) ? {8'h61 + 8'($urandom_range(25)), 32'($urandom)}
                                      : rand_word();
         if ($urandom_range(5) == 0)
            k[15:0] = '0;
         near = 1'b0;
         foreach (key_pool[j])
            if (int'(start_slot(k)) - int'(start_slot(key_pool[j])) <= 4 &&
                int'(start_slot(key_pool[j])) - int'(start_slot(k)) <= 4)
               near = 1'b1;
         if (near)
            key_pool = {key_pool, k};
      end
      pair_a = rand_word();
      pair_b = find_key_at(start_slot(pair_a));
      while (fold_key(pair_b) == fold_key(pair_a))
         pair_b = find_key_at(start_slot(pair_a));
      top_a = find_key_at(10'd1023);
      top_b = find_key_at(10'd1023);
      while (fold_key(top_b) == fold_key(top_a))
         top_b = find_key_at(10'd1023);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: folding, empty keys, boundary characters, chains, wrap
      push_req(hkd_pkg::FUNC_INSERT, "Hello");
      push_req(hkd_pkg::FUNC_INSERT, "hello");
      push_req(hkd_pkg::FUNC_LOOKUP, "HELLO");
      push_req(hkd_pkg::FUNC_SPARE,  "hELLo");
      push_req(hkd_pkg::FUNC_REMOVE, "hello");
      push_req(hkd_pkg::FUNC_REMOVE, "Hello");
      push_req(hkd_pkg::FUNC_LOOKUP, "hello");
      push_req(hkd_pkg::FUNC_INSERT, 40'hFF_FFFF_FFFF);
      push_req(hkd_pkg::FUNC_LOOKUP, 40'hFF_FFFF_FFFF);
      push_req(hkd_pkg::FUNC_INSERT, 40'h00_415A_617A);
      push_req(hkd_pkg::FUNC_LOOKUP, 40'h00_0000_0000);
      push_req(hkd_pkg::FUNC_REMOVE, 40'h00_FFFF_FFFF);
      push_req(hkd_pkg::FUNC_INSERT, "@AZ[z");
      push_req(hkd_pkg::FUNC_LOOKUP, "@az[Z");
      push_req(hkd_pkg::FUNC_LOOKUP, 40'h60_617A_5B7A);
      push_req(hkd_pkg::FUNC_INSERT, 40'h41_0000_0000);
      push_req(hkd_pkg::FUNC_LOOKUP, 40'h61_0000_0000);
      push_req(hkd_pkg::FUNC_INSERT, pair_a);
      push_req(hkd_pkg::FUNC_INSERT, pair_b);
      push_req(hkd_pkg::FUNC_REMOVE, pair_a);
      push_req(hkd_pkg::FUNC_LOOKUP, pair_b);
      push_req(hkd_pkg::FUNC_INSERT, pair_b);
      push_req(hkd_pkg::FUNC_INSERT, top_a);
      push_req(hkd_pkg::FUNC_INSERT, top_b);
      push_req(hkd_pkg::FUNC_LOOKUP, top_b);
      wait_drained();

      // random traffic, with a full drain half way through
      for (int half = 0; half < 2; half++) begin
         for (int i = 0; i < 190; i++) begin
            roll = $urandom_range(99);
            if (roll < 70)
               k = mix_case(key_pool[$urandom_range(key_pool.size() - 1)]);
            else if (roll < 95)
               k = rand_any_key();
            else
               k = {8'h00, 32'($urandom)};
            push_req(rand_func(), k);
         end
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (errors == 0 && slot_status_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/hkd_pkg.sv
rtl/core/hkd_front.sv
rtl/core/hkd_queue.sv
rtl/core/hkd_back.sv
rtl/core/hashed_key_directory_linear_probe.sv
verif/hashed_key_directory_linear_probe_tb.sv
